FILE: sv/fel_pkg.sv
// ----------------------------------------------------------------------------
// fel_pkg: shared definitions for the FIFO eviction list
// Action and status codes, default sizes and the cell control bundle.
// ----------------------------------------------------------------------------
package fel_pkg;

    localparam int DEF_DEPTH      = 16;
    localparam int DEF_KEY_WIDTH  = 16;
    localparam int DEF_TIME_WIDTH = 64;

    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [ACTION_W-1:0] ACT_INSERT  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_REM_OLD = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_REM_KEY = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SWEEP   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

    // per-cell control; load wins over the shifts
    typedef struct packed {
        logic load;
        logic shift_l;
        logic shift_r;
    } t_cell_ctl;

endpackage

FILE: sv/fifo_eviction_list_with_expiry.sv
// ----------------------------------------------------------------------------
// fifo_eviction_list_with_expiry: age-ordered key list with expiry sweep
// Row of cells, oldest at cell 0, plus a sequencer for the five actions.
// ----------------------------------------------------------------------------
//  channel   signals                                          handshake
//  request   i_action i_entry_key i_expiry_time i_now_time   start & !busy
//  result    o_status o_removed_valid o_removed_key           o_strobe, 1 cycle
//            o_removed_count o_last
//
//  Insert, remove oldest, unknown actions and any action on an empty list:
//  result in the cycle after the request, busy stays low, one request a cycle.
//  Remove by key and sweep: busy in S_PASS, S_FINAL, S_FLUSH; one cell moves
//  through the head compare per cycle. Clear: one key out per cycle till empty.
//  Reset (i_rst_n low, synchronous) empties the list. Results cannot stall.
// ----------------------------------------------------------------------------
module fifo_eviction_list_with_expiry
    import fel_pkg::*;
#(
    parameter int DEPTH      = DEF_DEPTH,
    parameter int KEY_WIDTH  = DEF_KEY_WIDTH,
    parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [KEY_WIDTH-1:0]  i_entry_key,
    input  logic [TIME_WIDTH-1:0] i_expiry_time,
    input  logic [TIME_WIDTH-1:0] i_now_time,
    output logic                  o_strobe,
    output logic [STATUS_W-1:0]   o_status,
    output logic                  o_removed_valid,
    output logic [KEY_WIDTH-1:0]  o_removed_key,
    output logic [COUNT_W-1:0]    o_removed_count,
    output logic                  o_last
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PASS  = 3'd1;
    localparam logic [2:0] S_FINAL = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_CLEAR = 3'd4;

    logic [KEY_WIDTH-1:0]  key_q [DEPTH];
    logic [TIME_WIDTH-1:0] exp_q [DEPTH];
    t_cell_ctl             cell_ctl [DEPTH];

    logic [2:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_rem, n_rem;
    logic                  r_sweep, n_sweep;
    logic                  r_found, n_found;
    logic [KEY_WIDTH-1:0]  r_key, n_key;
    logic [TIME_WIDTH-1:0] r_now, n_now;
    logic [KEY_WIDTH-1:0]  r_hold_key, n_hold_key;
    logic [TIME_WIDTH-1:0] r_hold_exp, n_hold_exp;
    logic                  r_pend, n_pend;
    logic [KEY_WIDTH-1:0]  r_pend_key, n_pend_key;
    logic [COUNT_W-1:0]    r_pend_cnt, n_pend_cnt;
    logic [COUNT_W-1:0]    r_k, n_k;

    logic                  r_strobe, n_strobe;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic                  r_rvalid, n_rvalid;
    logic [KEY_WIDTH-1:0]  r_rkey, n_rkey;
    logic [COUNT_W-1:0]    r_rcount, n_rcount;
    logic                  r_last, n_last;

    logic                  shl, shr, ld_en;
    logic [IDX_W-1:0]      ld_idx;
    logic [KEY_WIDTH-1:0]  ld_key;
    logic [TIME_WIDTH-1:0] ld_exp;
    logic [CNT_W-1:0]      cnt_m1;
    logic                  head_hit, hold_hit;

    assign cnt_m1 = r_count - CNT_W'(1);

    assign head_hit = r_sweep ? (exp_q[0] <= r_now) : (!r_found && key_q[0] == r_key);
    assign hold_hit = r_sweep ? (r_hold_exp <= r_now) : (!r_found && r_hold_key == r_key);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [KEY_WIDTH-1:0]  left_key, right_key;
            logic [TIME_WIDTH-1:0] left_exp, right_exp;

            if (gi == 0) begin : g_first
                assign left_key = '0;
                assign left_exp = '0;
            end else begin : g_mid_l
                assign left_key = key_q[gi-1];
                assign left_exp = exp_q[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_last
                assign right_key = '0;
                assign right_exp = '0;
            end else begin : g_mid_r
                assign right_key = key_q[gi+1];
                assign right_exp = exp_q[gi+1];
            end

            // load, shift_l, shift_r
            assign cell_ctl[gi] = {ld_en && (ld_idx == IDX_W'(gi)), shl, shr};

            fel_cell #(
                .KEY_WIDTH  (KEY_WIDTH),
                .TIME_WIDTH (TIME_WIDTH)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (cell_ctl[gi]),
                .i_load_key  (ld_key),
                .i_load_exp  (ld_exp),
                .i_left_key  (left_key),
                .i_left_exp  (left_exp),
                .i_right_key (right_key),
                .i_right_exp (right_exp),
                .o_key       (key_q[gi]),
                .o_exp       (exp_q[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_rem      = r_rem;
        n_sweep    = r_sweep;
        n_found    = r_found;
        n_key      = r_key;
        n_now      = r_now;
        n_hold_key = r_hold_key;
        n_hold_exp = r_hold_exp;
        n_pend     = r_pend;
        n_pend_key = r_pend_key;
        n_pend_cnt = r_pend_cnt;
        n_k        = r_k;
        n_strobe   = 1'b0;
        n_status   = ST_DONE;
        n_rvalid   = 1'b0;
        n_rkey     = '0;
        n_rcount   = '0;
        n_last     = 1'b1;
        shl        = 1'b0;
        shr        = 1'b0;
        ld_en      = 1'b0;
        ld_idx     = '0;
        ld_key     = i_entry_key;
        ld_exp     = i_expiry_time;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_action)
                        ACT_INSERT: begin
                            n_strobe = 1'b1;
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                ld_en   = 1'b1;
                                ld_idx  = r_count[IDX_W-1:0];
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        ACT_REM_OLD: begin
                            n_strobe = 1'b1;
                            if (r_count == '0) begin
                                n_status = ST_NONE;
                            end else begin
                                n_rvalid = 1'b1;
                                n_rkey   = key_q[0];
                                n_rcount = COUNT_W'(1);
                                shl      = 1'b1;
                                n_count  = cnt_m1;
                            end
                        end
                        ACT_REM_KEY, ACT_SWEEP: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_status = ST_NONE;
                            end else begin
                                // oldest entry is visited last: park it aside
                                n_hold_key = key_q[0];
                                n_hold_exp = exp_q[0];
                                shl        = 1'b1;
                                n_count    = cnt_m1;
                                n_rem      = cnt_m1;
                                n_sweep    = (i_action == ACT_SWEEP);
                                n_key      = i_entry_key;
                                n_now      = i_now_time;
                                n_found    = 1'b0;
                                n_pend     = 1'b0;
                                n_k        = '0;
                                n_state    = (r_count == CNT_W'(1)) ? S_FINAL : S_PASS;
                            end
                        end
                        ACT_CLEAR: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_status = ST_NONE;
                            end else begin
                                n_k     = '0;
                                n_state = S_CLEAR;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end

            S_PASS: begin
                shl = 1'b1;
                if (head_hit) begin
                    n_count    = cnt_m1;
                    n_k        = r_k + COUNT_W'(1);
                    n_found    = 1'b1;
                    // a result is held back one removal so last can be marked
                    if (r_pend) begin
                        n_strobe = 1'b1;
                        n_rvalid = 1'b1;
                        n_rkey   = r_pend_key;
                        n_rcount = r_pend_cnt;
                        n_last   = 1'b0;
                    end
                    n_pend     = 1'b1;
                    n_pend_key = key_q[0];
                    n_pend_cnt = r_k + COUNT_W'(1);
                end else begin
                    // survivor wraps round to the tail
                    ld_en  = 1'b1;
                    ld_idx = cnt_m1[IDX_W-1:0];
                    ld_key = key_q[0];
                    ld_exp = exp_q[0];
                end
                n_rem = r_rem - CNT_W'(1);
                if (r_rem == CNT_W'(1)) begin
                    n_state = S_FINAL;
                end
            end

            S_FINAL: begin
                if (hold_hit) begin
                    n_k     = r_k + COUNT_W'(1);
                    n_found = 1'b1;
                    if (r_pend) begin
                        n_strobe = 1'b1;
                        n_rvalid = 1'b1;
                        n_rkey   = r_pend_key;
                        n_rcount = r_pend_cnt;
                        n_last   = 1'b0;
                    end
                    n_pend     = 1'b1;
                    n_pend_key = r_hold_key;
                    n_pend_cnt = r_k + COUNT_W'(1);
                end else begin
                    // oldest survives: push it back in at the head
                    shr     = 1'b1;
                    ld_en   = 1'b1;
                    ld_idx  = '0;
                    ld_key  = r_hold_key;
                    ld_exp  = r_hold_exp;
                    n_count = r_count + CNT_W'(1);
                end
                n_state = S_FLUSH;
            end

            S_FLUSH: begin
                n_strobe = 1'b1;
                if (r_pend) begin
                    n_rvalid = 1'b1;
                    n_rkey   = r_pend_key;
                    n_rcount = r_pend_cnt;
                end else begin
                    n_status = r_sweep ? ST_DONE : ST_NONE;
                end
                n_pend  = 1'b0;
                n_state = S_IDLE;
            end

            S_CLEAR: begin
                n_strobe = 1'b1;
                n_rvalid = 1'b1;
                n_rkey   = key_q[0];
                n_rcount = r_k + COUNT_W'(1);
                n_k      = r_k + COUNT_W'(1);
                n_last   = (r_count == CNT_W'(1));
                shl      = 1'b1;
                n_count  = cnt_m1;
                if (r_count == CNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_sweep    <= n_sweep;
        r_found    <= n_found;
        r_key      <= n_key;
        r_now      <= n_now;
        r_hold_key <= n_hold_key;
        r_hold_exp <= n_hold_exp;
        r_pend_key <= n_pend_key;
        r_pend_cnt <= n_pend_cnt;
        r_k        <= n_k;
        r_status   <= n_status;
        r_rvalid   <= n_rvalid;
        r_rkey     <= n_rkey;
        r_rcount   <= n_rcount;
        r_last     <= n_last;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_removed_valid = r_rvalid;
    assign o_removed_key   = r_rkey;
    assign o_removed_count = r_rcount;
    assign o_last          = r_last;

endmodule

FILE: sv/fel_cell.sv
// ----------------------------------------------------------------------------
// fel_cell: one slot of the eviction list
// Holds a key and an expiry time; loads new data or takes a neighbor's.
// ----------------------------------------------------------------------------
module fel_cell
    import fel_pkg::*;
#(
    parameter int KEY_WIDTH  = DEF_KEY_WIDTH,
    parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [KEY_WIDTH-1:0]  i_load_key,
    input  logic [TIME_WIDTH-1:0] i_load_exp,
    input  logic [KEY_WIDTH-1:0]  i_left_key,
    input  logic [TIME_WIDTH-1:0] i_left_exp,
    input  logic [KEY_WIDTH-1:0]  i_right_key,
    input  logic [TIME_WIDTH-1:0] i_right_exp,
    output logic [KEY_WIDTH-1:0]  o_key,
    output logic [TIME_WIDTH-1:0] o_exp
);

    logic [KEY_WIDTH-1:0]  r_key;
    logic [TIME_WIDTH-1:0] r_exp;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_key <= i_load_key;
            r_exp <= i_load_exp;
        end else if (i_ctl.shift_l) begin
            r_key <= i_right_key;
            r_exp <= i_right_exp;
        end else if (i_ctl.shift_r) begin
            r_key <= i_left_key;
            r_exp <= i_left_exp;
        end
    end

    assign o_key = r_key;
    assign o_exp = r_exp;

endmodule
